### src/ffsk_pkg.sv
`default_nettype none

package ffsk_pkg;

  localparam int TAPS       = 31;
  localparam int OVERSAMPLE = 10;
  localparam int SINE_DEPTH = 1024;

  localparam int COEF_COUNT = TAPS * OVERSAMPLE;
  localparam int COEF_AW    = $clog2(COEF_COUNT);
  localparam int ADDR_W     = $clog2(COEF_COUNT + OVERSAMPLE);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int SAMP_W     = $clog2(OVERSAMPLE);
  localparam int DEPTH_W    = $clog2(SINE_DEPTH);

  localparam int OPCODE_W   = 2;
  localparam int DIBIT_W    = 2;
  localparam int INDEX_W    = 9;
  localparam int COEF_W     = 16;
  localparam int STEP_W     = 13;
  localparam int SAMPLE_W   = 15;
  localparam int PHASE_W    = 16;
  localparam int FRAC_W     = 15;
  localparam int PROD_W     = STEP_W + COEF_W;
  // Only the low phase bits of the shifted sum survive, so the sum may wrap above them.
  localparam int ACC_W      = PHASE_W + FRAC_W;

  localparam logic [OPCODE_W-1:0] OP_MOD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BLANK = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COEF  = 2'd2;

  localparam logic signed [STEP_W-1:0] STEP_SMALL = 13'sd1092;
  localparam logic signed [STEP_W-1:0] STEP_LARGE = 13'sd3277;

  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned ONE_Q30   = 64'd1073741824;
  localparam longint unsigned AMPLITUDE = 64'd16383;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

  typedef struct packed {
    logic              coef_wr;
    logic              shift;
    logic              blank;
    logic              start;
    logic [SAMP_W-1:0] n;
    logic              issue;
    logic              phase_add;
    logic              lookup;
    logic              load_out;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic tap_last;
    logic mac_busy;
    logic out_free;
  } status_t;

  function automatic logic signed [STEP_W-1:0] step_of(input logic [DIBIT_W-1:0] dibit);
    logic signed [STEP_W-1:0] s;
    case (dibit)
      2'd0:    s = STEP_SMALL;
      2'd1:    s = STEP_LARGE;
      2'd2:    s = -STEP_SMALL;
      default: s = -STEP_LARGE;
    endcase
    return s;
  endfunction

  // Built at elaboration: quarter-wave Taylor series in Q30, then scaled and rounded.
  function automatic sine_rom_t sine_rom_init();
    sine_rom_t      t;
    longint unsigned theta, x2, term, pos, neg, s;
    logic           negate;
    int             k;
    for (k = 0; k < SINE_DEPTH; k++) begin
      theta  = (2 * PI_Q30 * longint'(k)) / SINE_DEPTH;
      negate = 1'b0;
      if (theta > PI_Q30) begin
        theta  = theta - PI_Q30;
        negate = 1'b1;
      end
      if (theta > PI_Q30 / 2) theta = PI_Q30 - theta;
      x2   = (theta * theta) >> 30;
      pos  = theta;
      // Each term divides by (2n)(2n+1); odd terms subtract.
      term = ((theta * x2) >> 30) / 64'd6;
      neg  = term;
      term = ((term * x2) >> 30) / 64'd20;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd42;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd72;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd110;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd156;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd210;
      neg  = neg + term;
      s    = (pos > neg) ? pos - neg : 64'd0;
      s    = (s * AMPLITUDE + (ONE_Q30 >> 1)) >> 30;
      t[k] = SAMPLE_W'(negate ? (64'd0 - s) : s);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### src/ffsk_ctrl.sv
`default_nettype none

module ffsk_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ffsk_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire ffsk_pkg::status_t                status,
  output ffsk_pkg::cmd_t                        cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PHASE  = 3'd3;
  localparam logic [2:0] S_LOOKUP = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [ffsk_pkg::SAMP_W-1:0] samp_r, samp_nxt;

  always_comb begin
    state_nxt = state_r;
    samp_nxt  = samp_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode) inside
            ffsk_pkg::OP_MOD, ffsk_pkg::OP_BLANK: begin
              cmd.shift = 1'b1;
              cmd.blank = (in_opcode == ffsk_pkg::OP_BLANK);
              cmd.start = 1'b1;
              cmd.n     = ffsk_pkg::SAMP_W'(ffsk_pkg::OVERSAMPLE - 1);
              samp_nxt  = ffsk_pkg::SAMP_W'(ffsk_pkg::OVERSAMPLE - 1);
              state_nxt = S_MAC;
            end
            ffsk_pkg::OP_COEF: cmd.coef_wr = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (status.tap_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.mac_busy) state_nxt = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase_add = 1'b1;
        state_nxt     = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = (samp_r == '0);
          if (samp_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.start = 1'b1;
            cmd.n     = samp_r - 1'b1;
            samp_nxt  = samp_r - 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      samp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      samp_r  <= samp_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ffsk_datapath.sv
`default_nettype none

module ffsk_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic        [ffsk_pkg::DIBIT_W-1:0]   in_dibit,
  input  wire logic        [ffsk_pkg::INDEX_W-1:0]   in_coef_index,
  input  wire logic signed [ffsk_pkg::COEF_W-1:0]    in_coef_value,
  input  wire ffsk_pkg::cmd_t                        cmd,
  output ffsk_pkg::status_t                          status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [ffsk_pkg::SAMPLE_W-1:0]  out_i_sample,
  output logic signed      [ffsk_pkg::SAMPLE_W-1:0]  out_q_sample,
  output logic                                       out_last
);

  localparam ffsk_pkg::sine_rom_t SINE_ROM = ffsk_pkg::sine_rom_init();

  logic signed [ffsk_pkg::STEP_W-1:0]   delay_r [ffsk_pkg::TAPS];
  logic signed [ffsk_pkg::COEF_W-1:0]   coef_mem [ffsk_pkg::COEF_COUNT];

  logic [ffsk_pkg::ADDR_W-1:0]          addr_r;
  logic [ffsk_pkg::TAP_W-1:0]           tap_r;
  logic signed [ffsk_pkg::COEF_W-1:0]   coef_q_r;
  logic signed [ffsk_pkg::STEP_W-1:0]   tap_q_r;
  logic signed [ffsk_pkg::ACC_W-1:0]    prod_r;
  logic signed [ffsk_pkg::ACC_W-1:0]    acc_r;
  logic                                 v1_r, v2_r;
  logic [ffsk_pkg::PHASE_W-1:0]         phase_r;
  logic signed [ffsk_pkg::SAMPLE_W-1:0] sin_r, cos_r;
  logic                                 out_valid_r;
  logic signed [ffsk_pkg::SAMPLE_W-1:0] out_i_r, out_q_r;
  logic                                 out_last_r;

  logic signed [ffsk_pkg::PROD_W-1:0]   prod_full;
  logic signed [ffsk_pkg::STEP_W-1:0]   new_step;
  logic [ffsk_pkg::DEPTH_W-1:0]         sidx, cidx;

  assign prod_full = tap_q_r * coef_q_r;
  assign new_step  = cmd.blank ? '0 : ffsk_pkg::step_of(in_dibit);
  assign sidx      = phase_r[ffsk_pkg::PHASE_W-1 -: ffsk_pkg::DEPTH_W];
  assign cidx      = sidx + ffsk_pkg::DEPTH_W'(ffsk_pkg::SINE_DEPTH / 4);

  assign status.tap_last = (tap_r == ffsk_pkg::TAP_W'(ffsk_pkg::TAPS - 1));
  assign status.mac_busy = v1_r | v2_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_i_sample = out_i_r;
  assign out_q_sample = out_q_r;
  assign out_last     = out_last_r;

  // Coefficient store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(in_coef_index) < ffsk_pkg::COEF_COUNT)) begin
      coef_mem[in_coef_index[ffsk_pkg::COEF_AW-1:0]] <= in_coef_value;
    end
    if (cmd.issue) begin
      coef_q_r <= coef_mem[addr_r[ffsk_pkg::COEF_AW-1:0]];
      tap_q_r  <= delay_r[tap_r];
    end
  end

  // Sine table read on two ports, both registered.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      sin_r <= SINE_ROM[sidx];
      cos_r <= SINE_ROM[cidx];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ffsk_pkg::ACC_W'(prod_full);
    if (cmd.start) begin
      addr_r <= ffsk_pkg::ADDR_W'(cmd.n);
      tap_r  <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.issue) begin
        addr_r <= addr_r + ffsk_pkg::ADDR_W'(ffsk_pkg::OVERSAMPLE);
        tap_r  <= tap_r + 1'b1;
      end
      if (v2_r) acc_r <= acc_r + prod_r;
    end
    if (cmd.load_out) begin
      out_i_r    <= cos_r;
      out_q_r    <= sin_r;
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ffsk_pkg::TAPS; k++) delay_r[k] <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The newest step enters at the top; tap zero holds the oldest.
      if (cmd.shift) begin
        for (int k = 0; k < ffsk_pkg::TAPS - 1; k++) delay_r[k] <= delay_r[k + 1];
        delay_r[ffsk_pkg::TAPS - 1] <= new_step;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.phase_add) begin
        phase_r <= phase_r + acc_r[ffsk_pkg::ACC_W-1:ffsk_pkg::FRAC_W];
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/fourfsk_rrc_modulator_unit.sv
// A symbol or blank beat yields 10 I/Q samples. For each sample, the 31 taps are
// summed on the single multiplier, the MAC pipeline drains, the phase is updated,
// the sine table is read and the output register is loaded. A coefficient write is
// taken while idle. The next beat is taken while the final sample waits.
// Synchronous active-low reset clears the delay line, phase, out_valid and FSM state.
`default_nettype none

module fourfsk_rrc_modulator_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic        [ffsk_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire logic        [ffsk_pkg::DIBIT_W-1:0]   in_dibit,
  input  wire logic        [ffsk_pkg::INDEX_W-1:0]   in_coef_index,
  input  wire logic signed [ffsk_pkg::COEF_W-1:0]    in_coef_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [ffsk_pkg::SAMPLE_W-1:0]  out_i_sample,
  output logic signed      [ffsk_pkg::SAMPLE_W-1:0]  out_q_sample,
  output logic                                       out_last
);

  ffsk_pkg::cmd_t    cmd;
  ffsk_pkg::status_t status;

  ffsk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd)
  );

  ffsk_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_dibit      (in_dibit),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_i_sample  (out_i_sample),
    .out_q_sample  (out_q_sample),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

### test/tb_fourfsk_rrc_modulator_unit.sv
`default_nettype none

module tb_fourfsk_rrc_modulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ffsk_pkg::*;

  // Opcode 3 has no name in the package; the block must drop it.
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

  typedef enum {COEF_RANDOM, COEF_SINGLE_TAP, COEF_NARROW} coef_set_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] i_s;
    logic signed [SAMPLE_W-1:0] q_s;
    logic                       last;
  } iq_t;

  // Keeps its own delay line, coefficient table and phase, and the I/Q samples still owed.
  class iq_sample_model;
    logic signed [SAMPLE_W-1:0] sine_lut [SINE_DEPTH];
    logic signed [COEF_W-1:0]   coef_mem [COEF_COUNT];
    logic signed [STEP_W-1:0]   step_line [TAPS];
    logic [PHASE_W-1:0]         phase_acc;
    iq_t                        pending_iq [$];
    int                         errors;

    function new();
      longint unsigned theta, x2, term, pos, neg, s;
      logic            negate;
      for (int k = 0; k < SINE_DEPTH; k++) begin
        theta  = (2 * PI_Q30 * longint'(k)) / SINE_DEPTH;
        negate = 1'b0;
        if (theta > PI_Q30) begin
          theta  = theta - PI_Q30;
          negate = 1'b1;
        end
        if (theta > PI_Q30 / 2) theta = PI_Q30 - theta;
        x2   = (theta * theta) >> 30;
        term = theta;
        pos  = theta;
        neg  = 0;
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) neg += term;
          else pos += term;
        end
        s = (pos > neg) ? pos - neg : 0;
        s = (s * AMPLITUDE + (ONE_Q30 >> 1)) >> 30;
        sine_lut[k] = negate ? -SAMPLE_W'(s) : SAMPLE_W'(s);
      end
      foreach (coef_mem[j]) coef_mem[j] = '0;
      foreach (step_line[j]) step_line[j] = '0;
      phase_acc = '0;
      errors    = 0;
    endfunction

    function void note_beat(logic [OPCODE_W-1:0] op, logic [DIBIT_W-1:0] dib,
                            logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      logic signed [STEP_W-1:0] step;
      longint                   acc;
      logic [PHASE_W-1:0]       inc;
      int                       sidx, cidx;
      iq_t                      smp;
      if (op == OP_COEF) begin
        if (idx < COEF_COUNT) coef_mem[idx] = val;
        return;
      end
      if (op == OP_SPARE) return;
      if (op == OP_BLANK) step = '0;
      else begin
        case (dib)
          2'd0:    step = STEP_SMALL;
          2'd1:    step = STEP_LARGE;
          2'd2:    step = -STEP_SMALL;
          default: step = -STEP_LARGE;
        endcase
      end
      for (int k = 0; k < TAPS - 1; k++) step_line[k] = step_line[k + 1];
      step_line[TAPS - 1] = step;
      for (int i = 0; i < OVERSAMPLE; i++) begin
        acc = 0;
        for (int k = 0; k < TAPS; k++)
          acc += longint'(step_line[k]) * longint'(coef_mem[OVERSAMPLE - 1 - i + k * OVERSAMPLE]);
        // Floor shift by 15, keeping only the bits the wrapping phase can see.
        inc       = acc[FRAC_W +: PHASE_W];
        phase_acc = phase_acc + inc;
        sidx      = int'((longint'(phase_acc) * SINE_DEPTH) >> PHASE_W) % SINE_DEPTH;
        cidx      = (sidx + SINE_DEPTH / 4) % SINE_DEPTH;
        smp.i_s   = sine_lut[cidx];
        smp.q_s   = sine_lut[sidx];
        smp.last  = (i == OVERSAMPLE - 1);
        pending_iq.push_back(smp);
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] i_s,
                               logic signed [SAMPLE_W-1:0] q_s, logic last);
      iq_t want;
      if (pending_iq.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected sample i=%0d q=%0d last=%0b", i_s, q_s, last);
        return;
      end
      want = pending_iq.pop_front();
      if (i_s !== want.i_s || q_s !== want.q_s || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: want i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                   want.i_s, want.q_s, want.last, i_s, q_s, last);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OPCODE_W-1:0]        in_opcode = '0;
  logic [DIBIT_W-1:0]         in_dibit = '0;
  logic [INDEX_W-1:0]         in_coef_index = '0;
  logic signed [COEF_W-1:0]   in_coef_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_i_sample;
  logic signed [SAMPLE_W-1:0] out_q_sample;
  logic                       out_last;

  int             in_idle_pct = 0;
  int             out_idle_pct = 0;
  iq_sample_model iq_model = new();

  fourfsk_rrc_modulator_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_dibit      (in_dibit),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_i_sample  (out_i_sample),
    .out_q_sample  (out_q_sample),
    .out_last      (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      iq_model.check_sample(out_i_sample, out_q_sample, out_last);
    out_ready <= (int'($urandom_range(99)) >= out_idle_pct);
  end

  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [DIBIT_W-1:0] dib,
                           input logic [INDEX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
    while (int'($urandom_range(99)) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_dibit      <= dib;
    in_coef_index <= idx;
    in_coef_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    iq_model.note_beat(op, dib, idx, val);
  endtask

  // Fills every entry of the table; the random set also mixes in beats the block must drop.
  task automatic load_coefs(input coef_set_t kind);
    logic signed [COEF_W-1:0] val;
    int                       tap;
    for (int idx = 0; idx < COEF_COUNT; idx++) begin
      tap = idx / OVERSAMPLE;
      case (kind)
        COEF_RANDOM: begin
          if (idx == 0) val = COEF_MIN;
          else if (idx == COEF_COUNT - 1) val = COEF_MAX;
          else val = COEF_W'($urandom);
          if ($urandom_range(19) == 0)
            send_beat(OP_COEF, DIBIT_W'($urandom),
                      INDEX_W'($urandom_range(2 ** INDEX_W - 1, COEF_COUNT)), COEF_W'($urandom));
          if ($urandom_range(29) == 0)
            send_beat(OP_SPARE, DIBIT_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
        end
        COEF_SINGLE_TAP: begin
          if (tap == TAPS - 1) val = COEF_MAX;
          else if (tap == 0) val = COEF_MIN;
          else val = '0;
        end
        default: val = COEF_W'(int'($urandom_range(4000)) - 2000);
      endcase
      send_beat(OP_COEF, DIBIT_W'($urandom), INDEX_W'(idx), val);
    end
  endtask

  task automatic run_directed();
    for (int d = 0; d < 4; d++) send_beat(OP_MOD, DIBIT_W'(d), '0, '0);
    send_beat(OP_BLANK, 2'd3, '1, COEF_MAX);
    repeat (3) send_beat(OP_MOD, 2'd3, '1, COEF_MIN);
    repeat (3) send_beat(OP_MOD, 2'd1, '0, '0);
    send_beat(OP_SPARE, 2'd3, '1, COEF_MIN);
    // Writes past the end of the table are dropped without touching it.
    send_beat(OP_COEF, 2'd0, '1, COEF_MAX);
    send_beat(OP_COEF, 2'd0, INDEX_W'(COEF_COUNT), -16'sd1);
    repeat (2) send_beat(OP_BLANK, 2'd0, '0, '0);
    repeat (3) send_beat(OP_MOD, 2'd2, '0, '0);
    repeat (2) send_beat(OP_MOD, 2'd0, '0, '0);
    send_beat(OP_MOD, 2'd3, '0, '0);
  endtask

  task automatic run_random(input int count);
    int done, pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        send_beat(OP_MOD, DIBIT_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
        done++;
      end else if (pick < 84) begin
        send_beat(OP_BLANK, DIBIT_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
        done++;
      end else if (pick < 94) begin
        send_beat(OP_COEF, DIBIT_W'($urandom), INDEX_W'($urandom_range(COEF_COUNT - 1)),
                  COEF_W'($urandom));
        done++;
      end else if (pick < 97) begin
        send_beat(OP_COEF, DIBIT_W'($urandom),
                  INDEX_W'($urandom_range(2 ** INDEX_W - 1, COEF_COUNT)), COEF_W'($urandom));
      end else begin
        send_beat(OP_SPARE, DIBIT_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 18;
    out_idle_pct = 60;
    load_coefs(COEF_RANDOM);
    run_directed();
    run_random(40);

    in_idle_pct  = 60;
    out_idle_pct = 18;
    run_random(40);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(40);
    in_valid <= 1'b0;

    while (iq_model.pending_iq.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (iq_model.errors == 0)
      $display("tb_fourfsk_rrc_modulator_unit OK");
    else
      $display("tb_fourfsk_rrc_modulator_unit NOT OK");
    $finish;
  end

  initial begin
    #15ms;
    $display("tb_fourfsk_rrc_modulator_unit NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
